// ===== hw/rtl/line_circle_intersection_unit_assert.svh =====
// Assertion macros used by the line and circle intersection RTL.
`ifndef LINE_CIRCLE_INTERSECTION_UNIT_ASSERT_SVH
`define LINE_CIRCLE_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCI_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/lci_pkg.sv =====
// Types, widths and helpers for the line and circle intersection unit.
package lci_pkg;

    // Port widths.
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 136;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER = 2'd2;

    // Hit counts.
    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ONE  = 2'd1;
    localparam logic [1:0] HIT_TWO  = 2'd2;

    // Internal widths of the datapath.
    localparam int AA_W   = 63;            // quadratic leading term
    localparam int D2_W   = 62;            // diameter squared
    localparam int K_W    = 63;            // magnitude of the offset term
    localparam int B_W    = 96;            // linear term magnitude
    localparam int ROOT_W = 63;            // square root result
    localparam int E_W    = 125;           // discriminant
    localparam int TR_W   = E_W + 2;       // square root trial value
    localparam int N_W    = 98;            // signed numerator
    localparam int RM_W   = 106;           // divider remainder
    localparam int QT_W   = 41;            // quotient bits kept
    localparam logic [QT_W-1:0] U_LIM = QT_W'(1) << (QT_W - 1);

    // Per-word context carried down the whole pipeline.
    typedef struct packed {
        logic              mode;
        logic signed [31:0] slope;
        logic signed [31:0] icpt;
        logic [1:0]        hits;
    } t_ctx;

    // Side data traveling with the square root stages.
    typedef struct packed {
        t_ctx            ctx;
        logic [AA_W-1:0] aa;
        logic            bneg;
        logic [B_W-1:0]  b;
    } t_sq_side;

    // Side data traveling with the divider stages.
    typedef struct packed {
        t_ctx              ctx;
        logic [ROOT_W-1:0] root;
        logic [63:0]       d;
        logic [1:0]        neg;
        logic [1:0]        ovf;
    } t_dv_side;

    // Result word, hit count in the lowest bits.
    typedef struct packed {
        logic signed [31:0] second_y;
        logic signed [31:0] second_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_x;
        logic [1:0]         hit_count;
    } t_res;

    // Clamp a 64 bit signed value to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/line_circle_intersection_unit.sv =====
// Line and circle intersection unit: quadratic build, pipelined root and divide.
//
// Intersects one line per word with a circle set through the configuration
// port (center x, center y, diameter; all Q16.16 by default). tuser[0] selects
// a sloped line y = slope*x + intercept (0) or a vertical line x = intercept (1).
// The unit takes one word per clock unless the output stalls, and returns one result
// word per input word, in order. A word passes through 117 register stages; most of
// the depth is the 63-stage digit-by-digit square root followed by two 41-stage
// restoring dividers running side by side. A two-entry output buffer decouples the
// result side, so the input stays ready while one finished result waits; a stall
// freezes the whole pipeline without loss. Configuration is taken every cycle and
// must only change while no word is in flight.
`include "line_circle_intersection_unit_assert.svh"

module line_circle_intersection_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lci_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lci_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Line input: tdata = slope[31:0], intercept[63:32].
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [lci_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser = mode[0].
    input  logic [lci_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    // Result: tdata = hit_count[1:0], first_x[33:2], first_y[65:34],
    // second_x[97:66], second_y[129:98], zero above.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [lci_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import lci_pkg::*;

    localparam int F = COORD_FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (F - 1);

    // Configuration registers.
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [30:0]        r_diameter;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_diameter <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_DIAMETER: r_diameter <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: the whole pipe moves unless the skid entry is taken.
    logic r_skid_valid;
    logic r_out_valid;
    logic w_en;

    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    // Stage 0: input word register.
    logic r0_v;
    t_ctx r0_ctx;

    // Stage 1: first products and differences.
    logic               r1_v;
    t_ctx               r1_ctx;
    logic signed [63:0] r1_mcx;
    logic [63:0]        r1_msq;
    logic [D2_W-1:0]    r1_d2;
    logic signed [32:0] r1_cmy;
    logic signed [32:0] r1_w;

    // Stage 2: leading term and offset magnitude.
    logic            r2_v;
    t_ctx            r2_ctx;
    logic [AA_W-1:0] r2_aa;
    logic            r2_kneg;
    logic [K_W-1:0]  r2_kabs;
    logic [D2_W-1:0] r2_d2;

    // Stage 3: 32 by 32 partial products.
    logic            r3_v;
    t_ctx            r3_ctx;
    logic [AA_W-1:0] r3_aa;
    logic            r3_bneg;
    logic [63:0]     r3_p_ll, r3_p_lh, r3_p_hl, r3_p_hh;
    logic [63:0]     r3_t_ll, r3_t_lh, r3_t_hh;
    logic [63:0]     r3_b_lo, r3_b_hi;

    // Stage 4: summed products.
    logic            r4_v;
    t_ctx            r4_ctx;
    logic [AA_W-1:0] r4_aa;
    logic            r4_bneg;
    logic [127:0]    r4_p;
    logic [127:0]    r4_q2;
    logic [B_W-1:0]  r4_b;

    // Square root stages; index 0 holds the discriminant.
    logic              r_sq_v    [0:ROOT_W];
    logic [E_W-1:0]    r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [0:ROOT_W];
    t_sq_side          r_sq_side [0:ROOT_W];

    // Numerator stages.
    logic              r_v1_v;
    t_ctx              r_v1_ctx;
    logic [AA_W-1:0]   r_v1_aa;
    logic [ROOT_W-1:0] r_v1_root;
    logic [N_W-1:0]    r_v1_n [2];

    logic              r_v2_v;
    t_ctx              r_v2_ctx;
    logic [63:0]       r_v2_d;
    logic [ROOT_W-1:0] r_v2_root;
    logic [1:0]        r_v2_neg;
    logic [N_W-1:0]    r_v2_nn [2];

    // Divider stages, two lanes; index 0 holds dividend and overflow flag.
    logic            r_dv_v    [0:QT_W];
    t_dv_side        r_dv_side [0:QT_W];
    logic [RM_W-1:0] r_dv_rem  [0:QT_W][2];
    logic [QT_W-1:0] r_dv_q    [0:QT_W][2];

    // Final stages.
    logic               r_f1_v;
    t_ctx               r_f1_ctx;
    logic signed [31:0] r_f1_x  [2];
    logic signed [31:0] r_f1_yv [2];

    logic               r_f2_v;
    t_ctx               r_f2_ctx;
    logic signed [31:0] r_f2_x  [2];
    logic signed [31:0] r_f2_yv [2];
    logic signed [63:0] r_f2_mx [2];

    logic r_f3_v;
    t_res r_f3_res;

    // Valid bits of the fixed stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v       <= 1'b0;
            r1_v       <= 1'b0;
            r2_v       <= 1'b0;
            r3_v       <= 1'b0;
            r4_v       <= 1'b0;
            r_sq_v[0]  <= 1'b0;
            r_v1_v     <= 1'b0;
            r_v2_v     <= 1'b0;
            r_dv_v[0]  <= 1'b0;
            r_f1_v     <= 1'b0;
            r_f2_v     <= 1'b0;
            r_f3_v     <= 1'b0;
        end else if (w_en) begin
            r0_v       <= i_s_axis_tvalid;
            r1_v       <= r0_v;
            r2_v       <= r1_v;
            r3_v       <= r2_v;
            r4_v       <= r3_v;
            r_sq_v[0]  <= r4_v;
            r_v1_v     <= r_sq_v[ROOT_W];
            r_v2_v     <= r_v1_v;
            r_dv_v[0]  <= r_v2_v;
            r_f1_v     <= r_dv_v[QT_W];
            r_f2_v     <= r_f1_v;
            r_f3_v     <= r_f2_v;
        end
    end

    // Stage 0 capture.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_ctx.mode  <= i_s_axis_tuser[0];
            r0_ctx.slope <= i_s_axis_tdata[31:0];
            r0_ctx.icpt  <= i_s_axis_tdata[63:32];
            r0_ctx.hits  <= HIT_NONE;
        end
    end

    // Stage 1: slope times center x, slope squared, diameter squared.
    logic [31:0] w0_mabs;
    assign w0_mabs = r0_ctx.slope[31] ? (32'd0 - r0_ctx.slope) : r0_ctx.slope;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ctx <= r0_ctx;
            r1_mcx <= r0_ctx.slope * r_center_x;
            r1_msq <= w0_mabs * w0_mabs;
            r1_d2  <= r_diameter * r_diameter;
            r1_cmy <= r0_ctx.icpt - r_center_y;
            r1_w   <= r0_ctx.icpt - r_center_x;
        end
    end

    // Stage 2: pick the quadratic terms; a vertical line uses a unit leading term.
    logic signed [63:0] w1_k2;
    logic signed [63:0] w1_kk;
    logic [63:0]        w1_kabs;
    logic [AA_W-1:0]    w1_a2;

    assign w1_k2   = r1_mcx + (64'(r1_cmy) <<< F);
    assign w1_a2   = (AA_W'(1) << (2 * F)) + AA_W'(r1_msq);
    assign w1_kk   = r1_ctx.mode ? 64'(r1_w) : w1_k2;
    assign w1_kabs = w1_kk[63] ? (64'd0 - w1_kk) : w1_kk;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ctx  <= r1_ctx;
            r2_aa   <= r1_ctx.mode ? AA_W'(1) : w1_a2;
            r2_kneg <= w1_kk[63];
            r2_kabs <= w1_kabs[K_W-1:0];
            r2_d2   <= r1_d2;
        end
    end

    // Stage 3: partial products of aa*d2, (2k)^2 and |m|*|k|.
    logic [31:0] w2_mabs;
    logic [63:0] w2_tk;

    assign w2_mabs = r2_ctx.slope[31] ? (32'd0 - r2_ctx.slope) : r2_ctx.slope;
    assign w2_tk   = {r2_kabs, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ctx  <= r2_ctx;
            r3_aa   <= r2_aa;
            r3_bneg <= (r2_ctx.slope[31] == r2_kneg);
            r3_p_ll <= r2_aa[31:0] * r2_d2[31:0];
            r3_p_lh <= r2_aa[31:0] * r2_d2[D2_W-1:32];
            r3_p_hl <= r2_aa[AA_W-1:32] * r2_d2[31:0];
            r3_p_hh <= r2_aa[AA_W-1:32] * r2_d2[D2_W-1:32];
            r3_t_ll <= w2_tk[31:0] * w2_tk[31:0];
            r3_t_lh <= w2_tk[31:0] * w2_tk[63:32];
            r3_t_hh <= w2_tk[63:32] * w2_tk[63:32];
            r3_b_lo <= w2_mabs * r2_kabs[31:0];
            r3_b_hi <= w2_mabs * r2_kabs[K_W-1:32];
        end
    end

    // Stage 4: sum the partial products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ctx  <= r3_ctx;
            r4_aa   <= r3_aa;
            r4_bneg <= r3_bneg;
            r4_p    <= 128'(r3_p_ll) + (128'(r3_p_lh) << 32) + (128'(r3_p_hl) << 32)
                       + (128'(r3_p_hh) << 64);
            r4_q2   <= 128'(r3_t_ll) + (128'(r3_t_lh) << 33) + (128'(r3_t_hh) << 64);
            r4_b    <= (B_W'(r3_b_lo) + (B_W'(r3_b_hi) << 32)) << 1;
        end
    end

    // Stage 5: discriminant sign decides the hit count.
    logic [128:0] w4_diff;
    t_sq_side     w4_side;

    assign w4_diff = {1'b0, r4_p} - {1'b0, r4_q2};

    always_comb begin
        w4_side      = '{ctx: r4_ctx, aa: r4_aa, bneg: r4_bneg, b: r4_b};
        if (w4_diff[128]) begin
            w4_side.ctx.hits = HIT_NONE;
        end else if (w4_diff == '0) begin
            w4_side.ctx.hits = HIT_ONE;
        end else begin
            w4_side.ctx.hits = HIT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0]  <= w4_diff[E_W-1:0];
            r_sq_root[0] <= '0;
            r_sq_side[0] <= w4_side;
        end
    end

    // Square root: one result bit per stage, remainder kept as E - root^2.
    for (genvar j = 1; j <= ROOT_W; j++) begin : g_sq
        localparam int BIT = ROOT_W - j;
        logic [TR_W-1:0] w_tr;
        logic            w_ge;

        assign w_tr = (TR_W'(r_sq_root[j-1]) << (BIT + 1)) | (TR_W'(1) << (2 * BIT));
        assign w_ge = TR_W'(r_sq_rem[j-1]) >= w_tr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[j] <= r_sq_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[j]  <= w_ge ? E_W'(TR_W'(r_sq_rem[j-1]) - w_tr) : r_sq_rem[j-1];
                r_sq_root[j] <= w_ge ? (r_sq_root[j-1] | (ROOT_W'(1) << BIT))
                                     : r_sq_root[j-1];
                r_sq_side[j] <= r_sq_side[j-1];
            end
        end
    end

    // Numerators for both roots: base -/+ root*S, plus aa for rounding.
    logic [N_W-1:0] w_bs;
    logic [N_W-1:0] w_rs;
    t_sq_side       w_sqo;

    assign w_sqo = r_sq_side[ROOT_W];
    assign w_bs  = w_sqo.bneg ? (N_W'(0) - N_W'(w_sqo.b)) : N_W'(w_sqo.b);
    assign w_rs  = N_W'(r_sq_root[ROOT_W]) << F;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1_ctx  <= w_sqo.ctx;
            r_v1_aa   <= w_sqo.aa;
            r_v1_root <= r_sq_root[ROOT_W];
            r_v1_n[0] <= w_bs - w_rs + N_W'(w_sqo.aa);
            r_v1_n[1] <= w_bs + w_rs + N_W'(w_sqo.aa);
        end
    end

    // Fold negative numerators so an unsigned divide gives the floor.
    logic [63:0] w_v1_d;
    assign w_v1_d = {r_v1_aa, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v2_ctx  <= r_v1_ctx;
            r_v2_d    <= w_v1_d;
            r_v2_root <= r_v1_root;
            for (int l = 0; l < 2; l++) begin
                r_v2_neg[l] <= r_v1_n[l][N_W-1];
                r_v2_nn[l]  <= r_v1_n[l][N_W-1]
                               ? (N_W'(0) - r_v1_n[l] + N_W'(w_v1_d) - N_W'(1))
                               : r_v1_n[l];
            end
        end
    end

    // Divider entry: flag quotients beyond the kept width.
    logic [RM_W-1:0] w_dlim;
    assign w_dlim = RM_W'(r_v2_d) << QT_W;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0].ctx  <= r_v2_ctx;
            r_dv_side[0].root <= r_v2_root;
            r_dv_side[0].d    <= r_v2_d;
            r_dv_side[0].neg  <= r_v2_neg;
            for (int l = 0; l < 2; l++) begin
                r_dv_side[0].ovf[l] <= RM_W'(r_v2_nn[l]) >= w_dlim;
                r_dv_rem[0][l]      <= RM_W'(r_v2_nn[l]);
                r_dv_q[0][l]        <= '0;
            end
        end
    end

    // Restoring divide, one quotient bit per stage in each lane.
    for (genvar j = 1; j <= QT_W; j++) begin : g_dv
        localparam int BIT = QT_W - j;
        logic [RM_W-1:0] w_t;

        assign w_t = RM_W'(r_dv_side[j-1].d) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_side[j] <= r_dv_side[j-1];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic w_ge;
            assign w_ge = r_dv_rem[j-1][l] >= w_t;

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_rem[j][l] <= w_ge ? (r_dv_rem[j-1][l] - w_t) : r_dv_rem[j-1][l];
                    r_dv_q[j][l]   <= w_ge ? (r_dv_q[j-1][l] | (QT_W'(1) << BIT))
                                           : r_dv_q[j-1][l];
                end
            end
        end
    end

    // Final stage 1: clamp the offset, place x; vertical y from the half root.
    t_dv_side           w_dvo;
    logic [QT_W-1:0]    w_uq [2];
    logic signed [63:0] w_u  [2];
    logic [63:0]        w_h;

    assign w_dvo = r_dv_side[QT_W];
    assign w_h   = (64'(w_dvo.root) + 64'd1) >> 1;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_uq[l] = (w_dvo.ovf[l] || (r_dv_q[QT_W][l] > U_LIM)) ? U_LIM : r_dv_q[QT_W][l];
            w_u[l]  = w_dvo.neg[l] ? (64'sd0 - 64'(w_uq[l])) : 64'(w_uq[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_ctx   <= w_dvo.ctx;
            r_f1_x[0]  <= sat32(64'(r_center_x) + w_u[0]);
            r_f1_x[1]  <= sat32(64'(r_center_x) + w_u[1]);
            r_f1_yv[0] <= sat32(64'(r_center_y) - w_h);
            r_f1_yv[1] <= sat32(64'(r_center_y) + w_h);
        end
    end

    // Final stage 2: slope times x.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_ctx <= r_f1_ctx;
            r_f2_x   <= r_f1_x;
            r_f2_yv  <= r_f1_yv;
            for (int l = 0; l < 2; l++) begin
                r_f2_mx[l] <= r_f1_ctx.slope * r_f1_x[l];
            end
        end
    end

    // Final stage 3: rounded y, mode select and clearing of unused slots.
    logic signed [31:0] w_px [2];
    logic signed [31:0] w_py [2];
    t_res               w_res;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_f2_ctx.mode) begin
                w_px[l] = r_f2_ctx.icpt;
                w_py[l] = r_f2_yv[l];
            end else begin
                w_px[l] = r_f2_x[l];
                w_py[l] = sat32(64'(r_f2_ctx.icpt) + ((r_f2_mx[l] + HALF) >>> F));
            end
        end
        w_res = '0;
        w_res.hit_count = r_f2_ctx.hits;
        if (r_f2_ctx.hits != HIT_NONE) begin
            w_res.first_x = w_px[0];
            w_res.first_y = w_py[0];
        end
        if (r_f2_ctx.hits == HIT_TWO) begin
            w_res.second_x = w_px[1];
            w_res.second_y = w_py[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f3_res <= w_res;
        end
    end

    // Output register with one skid entry behind it.
    t_res r_out;
    t_res r_skid;
    logic w_push;
    logic w_pop;

    assign w_push = w_en && r_f3_v;
    assign w_pop  = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid) begin
            if (w_push && w_pop) begin
                r_out <= r_f3_res;
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end else if (w_push) begin
                r_skid       <= r_f3_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_push) begin
            r_out       <= r_f3_res;
            r_out_valid <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

    // Checks on the output buffer and result words.
    `LCI_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held while output register is empty")
    `LCI_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_valid && !i_m_axis_tready,
        r_skid_valid, "skid entry dropped without a transfer")
    `LCI_ASSERT_NOW(a_hit_range, i_clk, i_rst_n, r_out_valid,
        r_out.hit_count == HIT_NONE || r_out.hit_count == HIT_ONE
        || r_out.hit_count == HIT_TWO, "hit count out of range")
    `LCI_ASSERT_NOW(a_unused_zero, i_clk, i_rst_n,
        r_out_valid && r_out.hit_count != HIT_TWO,
        r_out.second_x == 32'sd0 && r_out.second_y == 32'sd0,
        "unused second point is not zero")

endmodule

// ===== tb/line_circle_intersection_unit_check.sv =====
// Checker for the line and circle intersection unit: predicts and compares result words.
`timescale 1ns / 100ps

module line_circle_intersection_unit_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [lci_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lci_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [lci_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic [lci_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [lci_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,
    output int                                o_errors,
    output int                                o_pending
);
    import lci_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [159:0] ULIMIT = 160'sd1 << 40;

    // Shadow copy of the circle registers.
    logic signed [31:0] circle_cx;
    logic signed [31:0] circle_cy;
    logic [30:0]        circle_dia;

    t_res crossings_due[$];

    // Clamp a wide signed value to the signed 32 bit coordinate range.
    function automatic logic signed [31:0] clamp_coord(input logic signed [159:0] v);
        if (v > 160'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -160'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Integer square root, rounded down.
    function automatic logic [63:0] floor_root(input logic [127:0] e);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= e) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Floor division by a positive divisor, clamped to plus or minus 2^40.
    function automatic logic signed [159:0] floor_div_clamped(input logic signed [159:0] n,
                                                              input logic signed [159:0] d);
        logic signed [159:0] q;
        if (n < 0) begin
            q = (-n + d - 1) / d;
            return (q > ULIMIT) ? -ULIMIT : -q;
        end
        q = n / d;
        return (q > ULIMIT) ? ULIMIT : q;
    endfunction

    // Work out the crossing points of one line with the current circle.
    function automatic t_res predict_crossing(input logic vertical,
                                              input logic signed [31:0] slope,
                                              input logic signed [31:0] icpt);
        t_res                res;
        logic signed [159:0] m, c, cx, cy, dd, k, a, w, e, lhs, rhs, num, u, x;
        logic [63:0]         q, h;
        res = '0;
        m   = slope;
        c   = icpt;
        cx  = circle_cx;
        cy  = circle_cy;
        dd  = $signed({129'd0, circle_dia});
        if (vertical) begin
            w   = c - cx;
            lhs = dd * dd;
            rhs = 4 * w * w;
            if (lhs < rhs) begin
                return res;
            end
            res.hit_count = (lhs == rhs) ? HIT_ONE : HIT_TWO;
            e = lhs - rhs;
            q = floor_root(e[127:0]);
            h = ({1'b0, q} + 65'd1) >> 1;
            res.first_x = icpt;
            res.first_y = clamp_coord(cy - $signed({96'd0, h}));
            if (res.hit_count == HIT_TWO) begin
                res.second_x = icpt;
                res.second_y = clamp_coord(cy + $signed({96'd0, h}));
            end
            return res;
        end
        k   = m * cx + ((c - cy) <<< FRAC);
        a   = (160'sd1 <<< (2 * FRAC)) + m * m;
        lhs = a * dd * dd;
        rhs = 4 * k * k;
        if (lhs < rhs) begin
            return res;
        end
        res.hit_count = (lhs == rhs) ? HIT_ONE : HIT_TWO;
        e = lhs - rhs;
        q = floor_root(e[127:0]);
        for (int i = 0; i < 2; i++) begin
            // Minus root first, then plus root.
            num = -2 * m * k;
            if (i == 0) begin
                num = num - ($signed({96'd0, q}) <<< FRAC);
            end else begin
                num = num + ($signed({96'd0, q}) <<< FRAC);
            end
            u = floor_div_clamped(num + a, 2 * a);
            x = clamp_coord(cx + u);
            if (i == 0) begin
                res.first_x = x[31:0];
                res.first_y = clamp_coord(c + ((m * x + (160'sd1 <<< (FRAC - 1))) >>> FRAC));
            end else if (res.hit_count == HIT_TWO) begin
                res.second_x = x[31:0];
                res.second_y = clamp_coord(c + ((m * x + (160'sd1 <<< (FRAC - 1))) >>> FRAC));
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result %s mismatch: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            circle_cx  = '0;
            circle_cy  = '0;
            circle_dia = '0;
            crossings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X: circle_cx = i_cfg_data;
                    CFG_CENTER_Y: circle_cy = i_cfg_data;
                    CFG_DIAMETER: circle_dia = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                crossings_due.insert(crossings_due.size(), predict_crossing(i_s_axis_tuser[0],
                    i_s_axis_tdata[31:0], i_s_axis_tdata[63:32]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_res'(i_m_axis_tdata[$bits(t_res)-1:0]);
                if (crossings_due.size() == 0) begin
                    // A result word with no line waiting for it.
                    report_mismatch("presence", 1, 0);
                end else begin
                    want = crossings_due.pop_front();
                    if (got.hit_count != want.hit_count)
                        report_mismatch("hit_count", got.hit_count, want.hit_count);
                    if (got.first_x != want.first_x)
                        report_mismatch("first_x", got.first_x, want.first_x);
                    if (got.first_y != want.first_y)
                        report_mismatch("first_y", got.first_y, want.first_y);
                    if (got.second_x != want.second_x)
                        report_mismatch("second_x", got.second_x, want.second_x);
                    if (got.second_y != want.second_y)
                        report_mismatch("second_y", got.second_y, want.second_y);
                end
            end
        end
        o_pending = crossings_due.size();
    end

endmodule

// ===== tb/line_circle_intersection_unit_test.sv =====
// Testbench top for the line and circle intersection unit: stimulus and verdict.
`timescale 1ns / 100ps

module line_circle_intersection_unit_test;
    import lci_pkg::*;

    localparam int DRAIN_CYCLES = 140;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]   i_s_axis_tuser = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    int                      errors;
    int                      pending;

    // Stimulus-side copy of the circle, used to aim lines at it.
    logic signed [31:0]      aim_cx = '0;
    logic signed [31:0]      aim_cy = '0;
    logic [30:0]             aim_dia = '0;
    bit                      calm = 1'b0;
    bit                      hold_off = 1'b0;
    int                      hold_left = 0;

    line_circle_intersection_unit dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .i_s_axis_tvalid, .o_s_axis_tready, .i_s_axis_tdata, .i_s_axis_tuser,
        .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata
    );

    line_circle_intersection_unit_check check (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_s_axis_tvalid, .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata, .i_s_axis_tuser, .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready, .i_m_axis_tdata(o_m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random back pressure, quiet stretches and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_off && hold_left == 0) begin
            hold_left = 400;
            hold_off  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else if (calm) begin
            i_m_axis_tready = 1'b1;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= 16);
        end
    end

    // Write one circle register and keep the aiming copy in step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        bit taken;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do begin
            #1 taken = o_cfg_ready;
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid = 1'b0;
        case (idx)
            CFG_CENTER_X: aim_cx = value;
            CFG_CENTER_Y: aim_cy = value;
            default:      aim_dia = value[30:0];
        endcase
    endtask

    task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] dia);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_DIAMETER, dia);
    endtask

    // Offer one line word, with an occasional gap in front, until it is taken.
    task automatic send_line(input logic vertical, input logic [31:0] slope,
                             input logic [31:0] icpt);
        bit taken;
        while (!calm && $urandom_range(0, 99) < 16) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = vertical;
        i_s_axis_tdata  = {icpt, slope};
        do begin
            #1 taken = o_s_axis_tready;
            @(negedge i_clk);
        end while (!taken);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Wait until every line has its result, then let the pipeline settle.
    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // A line mostly aimed near the circle, sometimes anything at all.
    task automatic random_line;
        logic               vertical;
        logic signed [31:0] slope;
        longint             base;
        longint             reach;
        longint             icpt;
        vertical = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: slope = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
            1: slope = $urandom;
            2: slope = '0;
            default: slope = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
        reach = longint'(aim_dia) / 2 + 2;
        if ($urandom_range(0, 99) < 10) begin
            icpt = $signed($urandom);
        end else if (vertical) begin
            icpt = longint'(aim_cx) + $signed(longint'($urandom_range(0, 2 * reach))) - reach;
            if (!aim_dia[0] && $urandom_range(0, 9) == 0)
                icpt = longint'(aim_cx) + ($urandom_range(0, 1) ? reach - 2 : 2 - reach);
        end else begin
            base = longint'(aim_cy) - ((longint'(slope) * longint'(aim_cx)) >>> 16);
            icpt = base + $signed(longint'($urandom_range(0, 2 * reach))) - reach;
        end
        if (icpt > 64'sd2147483647) icpt = 64'sd2147483647;
        if (icpt < -64'sd2147483648) icpt = -64'sd2147483648;
        send_line(vertical, slope, icpt[31:0]);
    endtask

    task automatic random_phase(input int count);
        repeat (count) random_line();
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero diameter at reset: only lines through the center touch it.
        send_line(1'b0, 32'h0005_0000, 32'h0);
        send_line(1'b1, 32'hFFFF_FFFF, 32'h0);
        send_line(1'b0, 32'h0005_0000, 32'h1);
        send_line(1'b1, 32'h1234_5678, 32'h1);
        send_line(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // Circle at (1, -2) with diameter 4: secants, tangent, miss, extremes.
        set_circle(32'h0001_0000, 32'hFFFE_0000, 32'h0004_0000);
        send_line(1'b0, 32'h0, 32'hFFFE_0000);
        send_line(1'b1, 32'h0, 32'h0001_0000);
        send_line(1'b1, 32'h0, 32'h0003_0000);
        send_line(1'b1, 32'hFFFF_FFFF, 32'hFFFF_0000);
        send_line(1'b1, 32'h0, 32'h0003_0001);
        send_line(1'b0, 32'h0001_0000, 32'hFFFD_0000);
        send_line(1'b0, 32'hFFFF_0000, 32'hFFFF_0000);
        send_line(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_line(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_line(1'b0, 32'hFFFF_FFFF, 32'h0);
        send_line(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_line(1'b0, 32'h0, 32'h7FFF_FFFF);
        drain();

        // Huge circle at the corner of the range: saturation.
        set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_line(1'b1, 32'h0, 32'h8000_0000);
        send_line(1'b0, 32'h0, 32'h7FFF_FFFF);
        send_line(1'b0, 32'h8000_0000, 32'h0);
        random_phase(120);

        set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        random_phase(60);

        // Result side held off long enough to fill the pipeline.
        set_circle(32'h0001_0000, 32'hFFFE_0000, 32'h0004_0000);
        hold_off = 1'b1;
        random_phase(160);

        // A stretch with no idling on either side.
        set_circle($urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF));
        calm = 1'b1;
        random_phase(160);
        calm = 1'b0;

        set_circle($urandom_range(0, 32'h000F_FFFF), $urandom_range(0, 32'h000F_FFFF),
                   $urandom_range(0, 32'h0010_0000));
        random_phase(150);

        set_circle($urandom, $urandom, $urandom >> 1);
        random_phase(130);

        if (errors == 0) begin
            $display("line_circle_intersection_unit_test: done, clean");
        end else begin
            $display("line_circle_intersection_unit_test: done, errors");
        end
        $finish;
    end

    // Hard stop if the handshakes never complete.
    initial begin
        #3_000_000;
        $display("line_circle_intersection_unit_test: done, errors");
        $finish;
    end

endmodule
